[rtl/arith_encoder_e1e2_scaling_defines.svh]
// Assertion macros shared by the checker of the arithmetic encoder.
// Depends on nothing; users must provide signals named clock and reset.
`ifndef ARITH_ENCODER_E1E2_SCALING_DEFINES_SVH
`define ARITH_ENCODER_E1E2_SCALING_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define AEE_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define AEE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/aee_pkg.sv]
// Shared constants, sequencer states and interface types of the arithmetic encoder.
// Used by the scaling divider and the top level; depends on nothing.
package aee_pkg;

   localparam int CODE_BITS = 32;
   localparam int COUNT_BITS = 16;
   localparam int MAX_SHIFTS = 32;

   localparam int RANGE_BITS = CODE_BITS + 1;
   localparam int PROD_BITS = RANGE_BITS + COUNT_BITS;
   localparam int DIV_STEPS = RANGE_BITS;
   localparam int DIV_CNT_BITS = $clog2(DIV_STEPS + 1);
   localparam int SHIFT_CNT_BITS = $clog2(MAX_SHIFTS + 1);
   localparam int SHIFT_IDX_BITS = $clog2(MAX_SHIFTS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_START_LO,
      S_WAIT_LO,
      S_START_HI,
      S_WAIT_HI,
      S_UPDATE,
      S_RENORM,
      S_EMIT
   } aee_state_type;

   typedef struct packed {
      logic                  start;
      logic [RANGE_BITS-1:0] range;
      logic [COUNT_BITS-1:0] count;
      logic [COUNT_BITS-1:0] total;
   } scale_req_type;

   typedef struct packed {
      logic                  done;
      logic [RANGE_BITS-1:0] quotient;
   } scale_rsp_type;

endpackage

[rtl/arith_encoder_e1e2_scaling.sv]
// Integer arithmetic encoder with E1/E2 renormalization, one symbol per item.
// Each item passes through two divisions by total_count in the shared aee_scale unit,
// each made of a start step, CODE_BITS + 1 quotient steps and a done step. Then come an
// update step, a step for each renormalization shift plus a closing step, the results at
// one per cycle while the result side does not stall, and the idle state, in which the
// next item is taken. Every result of an item carries the collapse flag as it stands
// after that item. The block is not ready for a new item until the last result of the
// current one has been taken.
module arith_encoder_e1e2_scaling
   import aee_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [COUNT_BITS-1:0] req_cum_low,
   input  logic [COUNT_BITS-1:0] req_cum_high,
   input  logic                  req_last_symbol,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_bit_valid,
   output logic                  rsp_code_bit,
   output logic                  rsp_run_end,
   output logic                  rsp_collapsed,
   output logic                  rsp_message_end,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [COUNT_BITS-1:0] csr_total_count
);

   aee_state_type             state_ff, state_in;
   logic [COUNT_BITS-1:0]     total_ff, total_in;
   logic [CODE_BITS-1:0]      lo_ff, lo_in;
   logic [CODE_BITS-1:0]      hi_ff, hi_in;
   logic                      collapse_ff, collapse_in;
   logic [COUNT_BITS-1:0]     cl_ff, cl_in;
   logic [COUNT_BITS-1:0]     ch_ff, ch_in;
   logic                      last_ff, last_in;
   logic [RANGE_BITS-1:0]     range_ff, range_in;
   logic [RANGE_BITS-1:0]     lo_off_ff, lo_off_in;
   logic [SHIFT_CNT_BITS-1:0] n_ff, n_in;
   logic [SHIFT_CNT_BITS-1:0] k_ff, k_in;
   logic [MAX_SHIFTS-1:0]     bits_ff, bits_in;

   scale_req_type             scale_req;
   scale_rsp_type             scale_rsp;

   logic [CODE_BITS-1:0]      hi_clamp;
   logic [RANGE_BITS-1:0]     lo_ext;
   logic [RANGE_BITS-1:0]     lo_adj;
   logic [RANGE_BITS-1:0]     lo_sum;
   logic [RANGE_BITS-1:0]     hi_sum;
   logic [RANGE_BITS-1:0]     width;
   logic                      e1;
   logic                      e2;
   logic                      shifts_full;
   logic                      emit_last;

   aee_scale u_scale (
      .clock (clock),
      .reset (reset),
      .req   (scale_req),
      .rsp   (scale_rsp)
   );

   assign scale_req.start = (state_ff == S_START_LO) || (state_ff == S_START_HI);
   assign scale_req.range = range_ff;
   assign scale_req.count = (state_ff == S_START_HI) ? ch_ff : cl_ff;
   assign scale_req.total = total_ff;

   assign hi_clamp    = (hi_ff < lo_ff) ? lo_ff : hi_ff;
   assign lo_ext      = {1'b0, lo_ff};
   assign lo_adj      = (lo_off_ff >= range_ff) ? (range_ff - RANGE_BITS'(1)) : lo_off_ff;
   assign lo_sum      = lo_ext + ((scale_rsp.quotient <= lo_off_ff) ? lo_adj : lo_off_ff);
   assign hi_sum      = lo_ext + scale_rsp.quotient - RANGE_BITS'(1);
   assign width       = {1'b0, hi_ff} - lo_ext + RANGE_BITS'(1);
   assign e1          = !hi_ff[CODE_BITS-1];
   assign e2          = lo_ff[CODE_BITS-1];
   assign shifts_full = (n_ff == SHIFT_CNT_BITS'(MAX_SHIFTS));
   assign emit_last   = (n_ff == '0) || (k_ff == (n_ff - SHIFT_CNT_BITS'(1)));

   assign req_stall       = (state_ff != S_IDLE);
   assign csr_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = (state_ff == S_EMIT);
   assign rsp_bit_valid   = (n_ff != '0);
   assign rsp_code_bit    = (n_ff != '0) && bits_ff[k_ff[SHIFT_IDX_BITS-1:0]];
   assign rsp_run_end     = emit_last;
   assign rsp_collapsed   = collapse_ff;
   assign rsp_message_end = emit_last && last_ff;

   always_comb begin
      state_in    = state_ff;
      total_in    = total_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      collapse_in = collapse_ff;
      cl_in       = cl_ff;
      ch_in       = ch_ff;
      last_in     = last_ff;
      range_in    = range_ff;
      lo_off_in   = lo_off_ff;
      n_in        = n_ff;
      k_in        = k_ff;
      bits_in     = bits_ff;

      if (csr_valid && csr_ready) begin
         total_in = (csr_total_count == '0) ? COUNT_BITS'(1) : csr_total_count;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cl_in    = (req_cum_low > total_ff) ? total_ff : req_cum_low;
               ch_in    = (req_cum_high > total_ff) ? total_ff : req_cum_high;
               last_in  = req_last_symbol;
               range_in = {1'b0, hi_clamp} - lo_ext + RANGE_BITS'(1);
               state_in = S_START_LO;
            end
         end
         S_START_LO: begin
            state_in = S_WAIT_LO;
         end
         S_WAIT_LO: begin
            if (scale_rsp.done) begin
               lo_off_in = scale_rsp.quotient;
               state_in  = S_START_HI;
            end
         end
         S_START_HI: begin
            state_in = S_WAIT_HI;
         end
         S_WAIT_HI: begin
            if (scale_rsp.done) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            lo_in = lo_sum[CODE_BITS-1:0];
            if (scale_rsp.quotient <= lo_off_ff) begin
               hi_in       = lo_sum[CODE_BITS-1:0];
               collapse_in = 1'b1;
            end else begin
               hi_in = hi_sum[CODE_BITS-1:0];
            end
            n_in     = '0;
            state_in = S_RENORM;
         end
         S_RENORM: begin
            if (!(e1 || e2) || shifts_full) begin
               if (((e1 || e2) && shifts_full) || (width < RANGE_BITS'(total_ff))) begin
                  collapse_in = 1'b1;
               end
               if (last_ff) begin
                  lo_in = '0;
                  hi_in = '1;
               end
               k_in     = '0;
               state_in = S_EMIT;
            end else begin
               lo_in = {lo_ff[CODE_BITS-2:0], 1'b0};
               hi_in = {hi_ff[CODE_BITS-2:0], 1'b1};
               bits_in[n_ff[SHIFT_IDX_BITS-1:0]] = !e1;
               n_in  = n_ff + SHIFT_CNT_BITS'(1);
            end
         end
         S_EMIT: begin
            if (!rsp_stall) begin
               if (emit_last) begin
                  state_in = S_IDLE;
               end else begin
                  k_in = k_ff + SHIFT_CNT_BITS'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         total_ff    <= COUNT_BITS'(1);
         lo_ff       <= '0;
         hi_ff       <= '1;
         collapse_ff <= 1'b0;
         n_ff        <= '0;
         k_ff        <= '0;
      end else begin
         state_ff    <= state_in;
         total_ff    <= total_in;
         lo_ff       <= lo_in;
         hi_ff       <= hi_in;
         collapse_ff <= collapse_in;
         n_ff        <= n_in;
         k_ff        <= k_in;
      end
      cl_ff     <= cl_in;
      ch_ff     <= ch_in;
      last_ff   <= last_in;
      range_ff  <= range_in;
      lo_off_ff <= lo_off_in;
      bits_ff   <= bits_in;
   end

endmodule

[rtl/aee_scale.sv]
// Iterative unit that computes floor(range * count / total), one quotient bit per cycle.
// Depends on aee_pkg for widths and the request and response types.
module aee_scale
   import aee_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  scale_req_type req,
   output scale_rsp_type rsp
);

   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                    done_ff, done_in;
   logic [COUNT_BITS-1:0]   rem_ff, rem_in;
   logic [RANGE_BITS-1:0]   qd_ff, qd_in;

   logic [PROD_BITS-1:0]    prod;
   logic [COUNT_BITS:0]     trial;
   logic [COUNT_BITS:0]     diff;
   logic                    ge;

   // The product's top bits are always below total, so only RANGE_BITS steps are needed.
   assign prod  = PROD_BITS'(req.range) * PROD_BITS'(req.count);
   assign trial = {rem_ff, qd_ff[RANGE_BITS-1]};
   assign ge    = trial >= {1'b0, req.total};
   assign diff  = trial - {1'b0, req.total};

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      qd_in   = qd_ff;
      if (req.start) begin
         cnt_in = DIV_CNT_BITS'(DIV_STEPS);
         rem_in = prod[PROD_BITS-1 -: COUNT_BITS];
         qd_in  = prod[RANGE_BITS-1:0];
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - DIV_CNT_BITS'(1);
         done_in = (cnt_ff == DIV_CNT_BITS'(1));
         rem_in  = ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
         qd_in   = {qd_ff[RANGE_BITS-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      qd_ff  <= qd_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = qd_ff;

endmodule

[rtl/aee_checker.sv]
// Port-level checker for the arithmetic encoder, attached to the top level by bind.
// Depends on the assertion macros in arith_encoder_e1e2_scaling_defines.svh.
`include "arith_encoder_e1e2_scaling_defines.svh"

module aee_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_bit_valid,
   input logic        rsp_code_bit,
   input logic        rsp_run_end,
   input logic        rsp_collapsed,
   input logic        rsp_message_end,
   input logic        csr_ready
);

   `AEE_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_bit_valid) && $stable(rsp_code_bit) && $stable(rsp_run_end) && $stable(rsp_message_end), "Stalled result item changed.")
   `AEE_ASSERT_NOW(a_idle_no_rsp, !req_stall, !rsp_valid && csr_ready, "Block takes items while a result is pending.")
   `AEE_ASSERT_NOW(a_empty_step, rsp_valid && !rsp_bit_valid, !rsp_code_bit && rsp_run_end, "Empty result item is malformed.")
   `AEE_ASSERT_NOW(a_msg_end, rsp_valid && rsp_message_end, rsp_run_end, "Message end shown off the final result item.")
   `AEE_ASSERT_NEXT(a_sticky, rsp_valid && !rsp_stall && rsp_collapsed, !rsp_valid || rsp_collapsed, "Collapse flag dropped.")

endmodule

bind arith_encoder_e1e2_scaling aee_checker u_aee_checker (.*);

[verif/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for arith_encoder_e1e2_scaling: symbol items with random gaps and
// result stalls, every emitted code bit checked against an in-bench encoder model.
// Depends on aee_pkg and the top level of the RTL.
module tb;
   import aee_pkg::*;

   localparam bit [63:0] CODE_MASK = (64'd1 << CODE_BITS) - 64'd1;
   localparam bit [63:0] CODE_HALF = 64'd1 << (CODE_BITS - 1);
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      bit [COUNT_BITS-1:0] cum_low;
      bit [COUNT_BITS-1:0] cum_high;
      bit                  last_symbol;
   } symbol_type;

   typedef struct {
      bit bit_valid;
      bit code_bit;
      bit run_end;
      bit collapsed;
      bit message_end;
   } coded_bit_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [COUNT_BITS-1:0] req_cum_low = '0;
   logic [COUNT_BITS-1:0] req_cum_high = '0;
   logic                  req_last_symbol = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_bit_valid;
   logic                  rsp_code_bit;
   logic                  rsp_run_end;
   logic                  rsp_collapsed;
   logic                  rsp_message_end;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [COUNT_BITS-1:0] csr_total_count = '0;

   symbol_type    symbol_q [$];
   coded_bit_type coded_bits_q [$];
   int            queued_symbols = 0;
   int            accepted_symbols = 0;
   int            result_count = 0;
   int            mismatch_count = 0;
   int            idle_cycles = 0;
   int            send_gap = 0;
   int            stall_left = 0;
   int            hold_left = 0;
   bit            hold_request = 1'b0;
   bit            send_quiet = 1'b0;
   bit            recv_quiet = 1'b0;

   bit [CODE_BITS-1:0]  enc_low;
   bit [CODE_BITS-1:0]  enc_high;
   bit                  enc_collapsed;
   bit [COUNT_BITS-1:0] enc_total;

   arith_encoder_e1e2_scaling dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cum_low     (req_cum_low),
      .req_cum_high    (req_cum_high),
      .req_last_symbol (req_last_symbol),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_bit_valid   (rsp_bit_valid),
      .rsp_code_bit    (rsp_code_bit),
      .rsp_run_end     (rsp_run_end),
      .rsp_collapsed   (rsp_collapsed),
      .rsp_message_end (rsp_message_end),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_total_count (csr_total_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         return $urandom_range(1, 3);
      end else if (pick < 92) begin
         return $urandom_range(4, 8);
      end
      return $urandom_range(20, 60);
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 50) begin
         $display("%0t: mismatch: %s", $time, what);
      end
   endtask

   function automatic bit [63:0] scaled_edge(bit [63:0] span, bit [63:0] count,
                                            bit [63:0] total);
      return (span / total) * count + ((span % total) * count) / total;
   endfunction

   // Narrows the interval for one symbol, renormalizes it and queues its expected result items.
   function automatic void encode_symbol(symbol_type sym);
      bit [63:0]     total;
      bit [63:0]     cl;
      bit [63:0]     ch;
      bit [63:0]     lo;
      bit [63:0]     hi;
      bit [63:0]     span;
      bit [63:0]     lo_off;
      bit [63:0]     hi_off;
      bit            shifted [$];
      coded_bit_type res;
      total = 64'(enc_total);
      if (total == 0) begin
         total = 64'd1;
      end
      cl = 64'(sym.cum_low);
      ch = 64'(sym.cum_high);
      if (cl > total) begin
         cl = total;
      end
      if (ch > total) begin
         ch = total;
      end
      lo = 64'(enc_low);
      hi = 64'(enc_high);
      if (hi < lo) begin
         hi = lo;
      end
      span = hi - lo + 64'd1;
      lo_off = scaled_edge(span, cl, total);
      hi_off = scaled_edge(span, ch, total);
      if (hi_off <= lo_off) begin
         if (lo_off >= span) begin
            lo_off = span - 64'd1;
         end
         lo = lo + lo_off;
         hi = lo;
         enc_collapsed = 1'b1;
      end else begin
         hi = lo + hi_off - 64'd1;
         lo = lo + lo_off;
      end
      while (hi < CODE_HALF || lo >= CODE_HALF) begin
         if (shifted.size() >= MAX_SHIFTS) begin
            enc_collapsed = 1'b1;
            break;
         end
         if (hi < CODE_HALF) begin
            lo = (lo << 1) & CODE_MASK;
            hi = ((hi << 1) | 64'd1) & CODE_MASK;
            shifted.insert(shifted.size(), 1'b0);
         end else begin
            lo = ((lo - CODE_HALF) << 1) & CODE_MASK;
            hi = (((hi - CODE_HALF) << 1) | 64'd1) & CODE_MASK;
            shifted.insert(shifted.size(), 1'b1);
         end
      end
      if (hi - lo + 64'd1 < total) begin
         enc_collapsed = 1'b1;
      end
      if (sym.last_symbol) begin
         lo = '0;
         hi = CODE_MASK;
      end
      enc_low = lo[CODE_BITS-1:0];
      enc_high = hi[CODE_BITS-1:0];
      if (shifted.size() == 0) begin
         res.bit_valid = 1'b0;
         res.code_bit = 1'b0;
         res.run_end = 1'b1;
         res.collapsed = enc_collapsed;
         res.message_end = sym.last_symbol;
         coded_bits_q.insert(coded_bits_q.size(), res);
      end else begin
         foreach (shifted[k]) begin
            res.bit_valid = 1'b1;
            res.code_bit = shifted[k];
            res.run_end = (k == shifted.size() - 1);
            res.collapsed = enc_collapsed;
            res.message_end = res.run_end && sym.last_symbol;
            coded_bits_q.insert(coded_bits_q.size(), res);
         end
      end
   endfunction

   task automatic compare_field(input string name, input logic got, input bit want);
      if (got !== want) begin
         report_mismatch($sformatf("result %0d %s: got %b, expected %b",
                                   result_count, name, got, want));
      end
   endtask

   always @(posedge clock) begin : sender
      symbol_type sym;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else if (!req_valid || !req_stall) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (symbol_q.size() > 0) begin
            sym = symbol_q.pop_front();
            req_valid <= 1'b1;
            req_cum_low <= sym.cum_low;
            req_cum_high <= sym.cum_high;
            req_last_symbol <= sym.last_symbol;
            send_gap = (send_quiet || $urandom_range(0, 99) < 60) ? 0 : idle_length();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         hold_left = 0;
      end else begin
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!recv_quiet && $urandom_range(0, 3) == 0) begin
            stall_left = idle_length() - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : monitor
      symbol_type    sym;
      coded_bit_type want;
      if (reset) begin
         enc_low = '0;
         enc_high = '1;
         enc_collapsed = 1'b0;
         enc_total = COUNT_BITS'(1);
         coded_bits_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            enc_total = csr_total_count;
         end
         if (req_valid && !req_stall) begin
            sym.cum_low = req_cum_low;
            sym.cum_high = req_cum_high;
            sym.last_symbol = req_last_symbol;
            encode_symbol(sym);
            accepted_symbols++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (coded_bits_q.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with nothing expected",
                                         result_count));
            end else begin
               want = coded_bits_q.pop_front();
               compare_field("bit_valid", rsp_bit_valid, want.bit_valid);
               compare_field("code_bit", rsp_code_bit, want.code_bit);
               compare_field("run_end", rsp_run_end, want.run_end);
               compare_field("collapsed", rsp_collapsed, want.collapsed);
               compare_field("message_end", rsp_message_end, want.message_end);
            end
            result_count++;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("** arith_encoder_e1e2_scaling: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_symbol(input int cl, input int ch, input bit last);
      symbol_type sym;
      sym.cum_low = COUNT_BITS'(cl);
      sym.cum_high = COUNT_BITS'(ch);
      sym.last_symbol = last;
      symbol_q.insert(symbol_q.size(), sym);
      queued_symbols++;
   endtask

   task automatic drain();
      while (accepted_symbols < queued_symbols || coded_bits_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   task automatic write_total(input int value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_total_count <= COUNT_BITS'(value);
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic random_phase(input int total, input int count, input bit hold);
      int span;
      int cl;
      int ch;
      write_total(total);
      span = (total == 0) ? 1 : total;
      send_quiet = hold || ($urandom_range(0, 3) == 0);
      recv_quiet = $urandom_range(0, 3) == 0;
      hold_request = hold;
      repeat (count) begin
         if ($urandom_range(0, 99) < 15) begin
            send_symbol($urandom_range(0, 65535), $urandom_range(0, 65535),
                        1'($urandom_range(0, 1)));
         end else begin
            cl = $urandom_range(0, span - 1);
            ch = $urandom_range(cl + 1, span);
            send_symbol(cl, ch, $urandom_range(0, 9) == 0);
         end
      end
      drain();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Total at its reset value: the full interval, no code bit emitted.
      send_symbol(0, 1, 1'b0);
      send_symbol(0, 1, 1'b1);
      drain();

      write_total(4);
      send_symbol(0, 1, 1'b0);
      send_symbol(3, 4, 1'b0);
      send_symbol(1, 3, 1'b0);
      send_symbol(0, 4, 1'b1);
      send_symbol(2, 9, 1'b1);
      send_symbol(5, 9, 1'b0);
      send_symbol(3, 1, 1'b0);
      send_symbol(2, 2, 1'b1);
      drain();

      write_total(65535);
      send_symbol(0, 65535, 1'b0);
      send_symbol(65534, 65535, 1'b0);
      send_symbol(0, 1, 1'b1);
      send_symbol(65535, 65535, 1'b0);
      drain();

      // A zero total behaves as a total of one.
      write_total(0);
      send_symbol(0, 1, 1'b0);
      send_symbol(0, 0, 1'b1);
      send_symbol(1, 1, 1'b0);
      drain();

      random_phase(65535, 90, 1'b0);
      random_phase($urandom_range(2, 64), 90, 1'b1);
      random_phase($urandom_range(1, 65535), 90, 1'b0);
      random_phase(1, 90, 1'b0);
      random_phase($urandom_range(100, 4000), 90, 1'b0);

      send_quiet = 1'b0;
      recv_quiet = 1'b0;
      repeat (150) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** arith_encoder_e1e2_scaling: PASSED **");
      end else begin
         $display("** arith_encoder_e1e2_scaling: FAILED **");
      end
      $finish;
   end

endmodule
